/* src/sensor_packet_deframer_macros.svh */
// assertion macros used by the deframer fifo
`ifndef SENSOR_PACKET_DEFRAMER_MACROS_SVH
`define SENSOR_PACKET_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold on every clock edge outside reset
`define SPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spd assertion failed");
// condition in one cycle implies a consequence in the next
`define SPD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("spd assertion failed");
`else
`define SPD_ASSERT(label, prop)
`define SPD_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* src/spd_pkg.sv */
// types and constants of the sensor packet deframer
`timescale 1ns / 1ps

package spd_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h55;

  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned OXY_W    = 24;
  localparam int unsigned PROD_W   = WORD_W + GAIN_W;

  typedef enum logic [1:0] {
    CFG_OXY_GAIN   = 2'd0,
    CFG_OXY_OFFSET = 2'd1,
    CFG_DEPTH_LIM  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   oxy_gain;
    logic [OFFSET_W-1:0] oxy_offset;
    logic [WORD_W-1:0]   depth_limit;
  } cfg_t;

  // raw words of one complete frame
  typedef struct packed {
    logic [WORD_W-1:0] oxygen;
    logic [WORD_W-1:0] pressure;
    logic [WORD_W-1:0] temperature;
    logic [WORD_W-1:0] depth;
  } frame_t;

  typedef struct packed {
    logic [OXY_W-1:0]  oxygen_milli;
    logic [WORD_W-1:0] pressure_tenths;
    logic [WORD_W-1:0] temperature_hundredths;
    logic [WORD_W-1:0] depth_cm;
  } result_t;

endpackage

/* src/spd_fifo.sv */
// small register based queue used between the deframer stages
`timescale 1ns / 1ps
`include "sensor_packet_deframer_macros.svh"

module spd_fifo #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SPD_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
  `SPD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
  `SPD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1)

endmodule

/* src/spd_frame_parser.sv */
// front end: byte framing state machine that collects the four sensor words
`timescale 1ns / 1ps

module spd_frame_parser
  import spd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       frame_push_o,
  output frame_t     frame_o
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_OXY_H  = 4'd1,
    PH_OXY_L  = 4'd2,
    PH_PRS_H  = 4'd3,
    PH_PRS_L  = 4'd4,
    PH_TMP_H  = 4'd5,
    PH_TMP_L  = 4'd6,
    PH_DEP_H  = 4'd7,
    PH_DEP_L  = 4'd8,
    PH_END    = 4'd9
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        high_byte_q;
  frame_t            frame_q;
  logic [WORD_W-1:0] word;

  assign word = {high_byte_q, byte_i};

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_OXY_H: phase_d = PH_OXY_L;
      PH_OXY_L: phase_d = PH_PRS_H;
      PH_PRS_H: phase_d = PH_PRS_L;
      PH_PRS_L: phase_d = PH_TMP_H;
      PH_TMP_H: phase_d = PH_TMP_L;
      PH_TMP_L: phase_d = PH_DEP_H;
      PH_DEP_H: phase_d = PH_DEP_L;
      PH_DEP_L: phase_d = PH_END;
      PH_END:   phase_d = PH_IDLE;
      default:  phase_d = (byte_i == START_BYTE) ? PH_OXY_H : PH_IDLE;
    endcase
  end

  // a start byte inside a frame is plain data, no resync
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      high_byte_q <= '0;
      frame_q     <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      unique case (phase_q)
        PH_OXY_H, PH_PRS_H, PH_TMP_H, PH_DEP_H: high_byte_q <= byte_i;
        PH_OXY_L: frame_q.oxygen      <= word;
        PH_PRS_L: frame_q.pressure    <= word;
        PH_TMP_L: frame_q.temperature <= word;
        PH_DEP_L: frame_q.depth       <= word;
        default: ;
      endcase
    end
  end

  assign frame_push_o = byte_valid_i && (phase_q == PH_END) && (byte_i == END_BYTE);
  assign frame_o      = frame_q;

endmodule

/* src/spd_scaler.sv */
// back end: oxygen calibration and depth limit, one register stage from frame pop to result push
`timescale 1ns / 1ps

module spd_scaler
  import spd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  frame_t  frame_i,
  input  logic    frame_empty_i,
  output logic    frame_pop_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  logic              s1_valid_q;
  logic [PROD_W-1:0] prod_q;
  logic [WORD_W-1:0] prs_q, tmp_q, dep_q;
  logic              advance;
  logic [PROD_W:0]   diff;

  assign advance     = !s1_valid_q || !res_full_i;
  assign frame_pop_o = !frame_empty_i && advance;
  assign res_push_o  = s1_valid_q && !res_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= !frame_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_pop_o) begin
      prod_q <= PROD_W'(frame_i.oxygen) * PROD_W'(cfg_i.oxy_gain);
      prs_q  <= frame_i.pressure;
      tmp_q  <= frame_i.temperature;
      dep_q  <= (frame_i.depth > cfg_i.depth_limit) ? '0 : frame_i.depth;
    end
  end

  // a 40 bit product shifted down by 16 always fits 24 bits, so no clamp on top
  assign diff = {1'b0, prod_q} - (PROD_W + 1)'(cfg_i.oxy_offset);

  always_comb begin
    res_o.oxygen_milli           = (prod_q > PROD_W'(cfg_i.oxy_offset))
                                   ? diff[PROD_W-1:PROD_W-OXY_W] : '0;
    res_o.pressure_tenths        = prs_q;
    res_o.temperature_hundredths = tmp_q;
    res_o.depth_cm               = dep_q;
  end

endmodule

/* src/sensor_packet_deframer.sv */
// top level of the sensor packet deframer
`timescale 1ns / 1ps

// Takes one received byte per clock (push/full) and hands out one decoded
// reading per good frame (empty/pop). A frame is the start byte 0xAA, four
// big-endian words (oxygen, pressure, temperature, depth) and the end byte
// 0x55; a bad end byte drops the frame. The byte framer never waits except
// when the frame queue (FRAME_DEPTH entries) is full, so full stays low while
// results are drained. After its end byte a frame is written to the frame
// queue, then to the scaler register, where the 16x24 oxygen multiply is
// registered as the frame is popped, then through the offset subtract into
// the result queue. Configuration writes take effect at once and are meant
// for when no frame is in flight.

module sensor_packet_deframer
  import spd_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH  = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [OXY_W-1:0]  oxygen_milli_o,
  output logic [WORD_W-1:0] pressure_tenths_o,
  output logic [WORD_W-1:0] temperature_hundredths_o,
  output logic [WORD_W-1:0] depth_cm_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  cfg_t    cfg_q;
  logic    byte_take;
  logic    frame_push, frame_pop, frame_full, frame_empty;
  frame_t  frame_in, frame_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oxy_gain    <= GAIN_W'(4756080);
      cfg_q.oxy_offset  <= OFFSET_W'(12649800);
      cfg_q.depth_limit <= WORD_W'(2000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OXY_GAIN:   cfg_q.oxy_gain    <= cfg_data_i[GAIN_W-1:0];
        CFG_OXY_OFFSET: cfg_q.oxy_offset  <= cfg_data_i[OFFSET_W-1:0];
        CFG_DEPTH_LIM:  cfg_q.depth_limit <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign full      = frame_full;
  assign byte_take = push && !frame_full;

  spd_frame_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_take),
    .byte_i       (rx_byte_i),
    .frame_push_o (frame_push),
    .frame_o      (frame_in)
  );

  spd_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .data_i  (frame_in),
    .full_o  (frame_full),
    .pop_i   (frame_pop),
    .data_o  (frame_out),
    .empty_o (frame_empty)
  );

  spd_scaler u_scaler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .frame_i       (frame_out),
    .frame_empty_i (frame_empty),
    .frame_pop_o   (frame_pop),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  spd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign oxygen_milli_o           = res_out.oxygen_milli;
  assign pressure_tenths_o        = res_out.pressure_tenths;
  assign temperature_hundredths_o = res_out.temperature_hundredths;
  assign depth_cm_o               = res_out.depth_cm;

endmodule
